### rtl/core/positional_list_engine_unit_macros.svh
// Assertion helpers for the positional list engine.
// The checks are compiled out when SYNTHESIS is defined.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("positional list engine check failed");

// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("positional list engine check failed");

`else

`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/ple_pkg.sv
package ple_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int ADDR_W     = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 7;

	// compare width for position against count
	localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	localparam int IN_DATA_W   = VALUE_W + POS_W;
	localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = STATUS_W + TOTAL_W + VALUE_W;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W;

	localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DISPLAY = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic                      we;
		logic [ADDR_W-1:0]         waddr;
		logic signed [VALUE_W-1:0] wdata;
		logic                      re;
		logic [ADDR_W-1:0]         raddr;
	} ram_req_t;

	typedef struct packed {
		logic                      load;
		logic [STATUS_W-1:0]       status;
		logic [TOTAL_W-1:0]        entry_total;
		logic signed [VALUE_W-1:0] element;
		logic                      element_valid;
		logic                      last;
	} result_t;

endpackage

### rtl/core/ple_ram.sv
module ple_ram import ple_pkg::*; (
	input  logic                      clk,
	input  ram_req_t                  req,
	output logic signed [VALUE_W-1:0] rd_data
);

	logic signed [VALUE_W-1:0] store_q [LIST_DEPTH];
	logic signed [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= store_q[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/ple_ctrl.sv
module ple_ctrl import ple_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	input  logic                      out_free,
	input  logic signed [VALUE_W-1:0] rd_data,
	output ram_req_t                  ram_req,
	output result_t                   res,
	output logic [CNT_W-1:0]          entry_total
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SHIFT  = 2'd1;
	localparam logic [1:0] S_DISP   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]                state_q, state_d;
	logic [CNT_W-1:0]          cnt_q, cnt_d;
	logic [CNT_W-1:0]          rem_q, rem_d;
	logic [ADDR_W-1:0]         rd_ptr_q, rd_ptr_d;
	logic [ADDR_W-1:0]         ins_addr_q, ins_addr_d;
	logic signed [VALUE_W-1:0] val_q, val_d;
	logic [STATUS_W-1:0]       status_q, status_d;
	logic                      ins_q, ins_d;
	logic                      rd_vld_s1, rd_vld_d;
	logic [ADDR_W-1:0]         rd_addr_s1;
	logic [CMP_W-1:0]          pos_c, cnt_c;

	assign pos_c       = CMP_W'(position);
	assign cnt_c       = CMP_W'(cnt_q);
	assign in_ready    = (state_q == S_IDLE);
	assign entry_total = cnt_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		rem_d      = rem_q;
		rd_ptr_d   = rd_ptr_q;
		ins_addr_d = ins_addr_q;
		val_d      = val_q;
		status_d   = status_q;
		ins_d      = ins_q;
		rd_vld_d   = 1'b0;
		ram_req       = '0;
		ram_req.raddr = rd_ptr_q;
		res             = '0;
		res.entry_total = TOTAL_W'(cnt_q);
		res.status      = ST_DONE;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (mode)
						MODE_INSERT: begin
							if (pos_c == '0 || pos_c > cnt_c + 1'b1) begin
								status_d = ST_BADPOS;
								state_d  = S_FINISH;
							end else if (cnt_q == CNT_W'(LIST_DEPTH)) begin
								status_d = ST_FULL;
								state_d  = S_FINISH;
							end else begin
								// entries p-1..n-1 move up one, read from the top down
								status_d   = ST_DONE;
								cnt_d      = cnt_q + 1'b1;
								ins_d      = 1'b1;
								val_d      = value;
								ins_addr_d = ADDR_W'(position - 1'b1);
								rd_ptr_d   = ADDR_W'(cnt_q - 1'b1);
								rem_d      = CNT_W'(cnt_c - pos_c + 1'b1);
								state_d    = S_SHIFT;
							end
						end
						MODE_DELETE: begin
							if (pos_c == '0 || pos_c > cnt_c) begin
								status_d = ST_BADPOS;
								state_d  = S_FINISH;
							end else begin
								// entries p..n-1 move down one, read from the bottom up
								status_d = ST_DONE;
								cnt_d    = cnt_q - 1'b1;
								ins_d    = 1'b0;
								rd_ptr_d = ADDR_W'(position);
								rem_d    = CNT_W'(cnt_c - pos_c);
								state_d  = S_SHIFT;
							end
						end
						MODE_DISPLAY: begin
							status_d = ST_DONE;
							if (cnt_q == '0) begin
								state_d = S_FINISH;
							end else begin
								rd_ptr_d = '0;
								rem_d    = cnt_q;
								state_d  = S_DISP;
							end
						end
						default: begin
							status_d = ST_BADPOS;
							state_d  = S_FINISH;
						end
					endcase
				end
			end
			S_SHIFT: begin
				if (rem_q != '0) begin
					ram_req.re = 1'b1;
					rd_vld_d   = 1'b1;
					rem_d      = rem_q - 1'b1;
					rd_ptr_d   = ins_q ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
				end
				// write back never lands on an entry that is still to be read
				if (rd_vld_s1) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = ins_q ? rd_addr_s1 + 1'b1 : rd_addr_s1 - 1'b1;
					ram_req.wdata = rd_data;
				end else if (rem_q == '0) begin
					ram_req.we    = ins_q;
					ram_req.waddr = ins_addr_q;
					ram_req.wdata = val_q;
					state_d       = S_FINISH;
				end
			end
			S_DISP: begin
				if (rd_vld_s1) begin
					res.load          = 1'b1;
					res.element       = rd_data;
					res.element_valid = 1'b1;
					res.last          = (rem_q == '0);
					if (rem_q == '0) begin
						state_d = S_IDLE;
					end
				end else if (rem_q != '0 && out_free) begin
					ram_req.re = 1'b1;
					rd_vld_d   = 1'b1;
					rem_d      = rem_q - 1'b1;
					rd_ptr_d   = rd_ptr_q + 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					res.load   = 1'b1;
					res.status = status_q;
					res.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rem_q     <= rem_d;
			rd_vld_s1 <= rd_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_q   <= rd_ptr_d;
		ins_addr_q <= ins_addr_d;
		val_q      <= val_d;
		status_q   <= status_d;
		ins_q      <= ins_d;
		rd_addr_s1 <= rd_ptr_q;
	end

endmodule

### rtl/core/positional_list_engine_unit.sv
// Positional list engine: an ordered list of up to LIST_DEPTH signed 32-bit entries.
// Input stream (s_axis): one transfer per command. tuser carries the mode
// (insert at position, delete at position, display all); tdata carries value and position.
// Output stream (m_axis): insert, delete and bad commands give one transfer with
// tlast set; display gives one transfer per entry in list order, tlast on the final
// one, or a single transfer with no element when the list is empty.
// Insert and delete hold the engine while they walk the entries that move, through the
// single-read, single-write list RAM, one entry per cycle, with a registered read.
// Display reads one entry at a time: the next RAM read is issued only after the
// previous entry has moved into the output register.
// The next command is taken as soon as the engine is back to idle, even while the
// last result still sits in the output register.
// Reset: count cleared, list empty; RAM contents are not cleared and are never read
// before being written. A stalled m_axis holds the result and pauses the display walk.
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit import ple_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [31:0] value, [38:32] position, rest zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] mode
	input  logic [MODE_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] status, [8:2] entry_total, [40:9] element, rest zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] element_valid
	output logic [0:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);

	ram_req_t                  ram_req;
	result_t                   res;
	logic signed [VALUE_W-1:0] rd_data;
	logic [CNT_W-1:0]          entry_total;
	logic                      out_free;

	// output register
	logic                      out_valid_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic [TOTAL_W-1:0]        out_total_q;
	logic signed [VALUE_W-1:0] out_elem_q;
	logic                      out_ev_q;
	logic                      out_last_q;

	// free this cycle if empty or being drained by the current transfer
	assign out_free = !out_valid_q || m_axis_tready;

	ple_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	ple_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.mode        (s_axis_tuser),
		.value       (s_axis_tdata[VALUE_W-1:0]),
		.position    (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
		.out_free    (out_free),
		.rd_data     (rd_data),
		.ram_req     (ram_req),
		.res         (res),
		.entry_total (entry_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			out_status_q <= res.status;
			out_total_q  <= res.entry_total;
			out_elem_q   <= res.element;
			out_ev_q     <= res.element_valid;
			out_last_q   <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_elem_q, out_total_q, out_status_q};
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;

	// count stays within the list size
	`PLE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, entry_total <= CNT_W'(LIST_DEPTH))
	// a new result never overwrites one still waiting
	`PLE_ASSERT_IMP(a_no_overwrite, clk, arst_n, res.load, out_free)
	// a result without an element is always the last one of its command
	`PLE_ASSERT_IMP(a_noelem_last, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
	// the engine is not ready again in the cycle after it takes a command
	`PLE_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

### tb/sv/tb.sv
module tb;
	import ple_pkg::*;

	// mode 3 has no operation behind it; the engine flags it as a bad position
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// generous bound: ~180 commands, each up to 64 results,
	// stretched by receiver stalls and sender gaps
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_PER_PH = 20;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [TOTAL_W-1:0]        entry_total;
		logic signed [VALUE_W-1:0] element;
		logic                      element_valid;
		logic                      last;
	} list_result_t;

	// directed row: typed = 1 means the single result is written out by hand
	typedef struct {
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		bit                        typed;
		logic [STATUS_W-1:0]       t_status;
		logic [TOTAL_W-1:0]        t_total;
	} cmd_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// [31:0] value, [38:32] position, rest zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	// [1:0] mode
	logic [MODE_W-1:0]      s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// [1:0] status, [8:2] entry_total, [40:9] element, rest zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// [0] element_valid
	logic [0:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	positional_list_engine_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// shadow copy of the list, updated at each accepted command
	logic signed [VALUE_W-1:0] list_vals [LIST_DEPTH];
	int                        list_count;

	list_result_t pending_results[$];  // expected transfers, oldest first
	list_result_t pred_batch[$];       // results of the command just predicted
	int           mismatch_count;
	int           cycle_count;
	int           send_idle_pct;
	int           recv_stall_pct;

	// directed part: empty-list corner cases, extreme values, every mode
	cmd_row_t dir_rows [18] = '{
		'{MODE_DISPLAY, 32'sd0,         7'd0,   1, ST_DONE,   7'd0},  // empty display
		'{MODE_DELETE,  32'sd0,         7'd1,   1, ST_BADPOS, 7'd0},  // delete from empty
		'{MODE_INSERT,  32'sd5,         7'd0,   1, ST_BADPOS, 7'd0},  // position zero
		'{MODE_INSERT,  32'sd5,         7'd2,   1, ST_BADPOS, 7'd0},  // past count+1
		'{MODE_INSERT,  32'sh7fffffff,  7'd1,   1, ST_DONE,   7'd1},
		'{MODE_INSERT,  32'sh80000000,  7'd1,   1, ST_DONE,   7'd2},
		'{MODE_INSERT,  -32'sd1,        7'd3,   1, ST_DONE,   7'd3},  // append at tail
		'{MODE_INSERT,  32'sd9,         7'd127, 1, ST_BADPOS, 7'd3},
		'{MODE_INSERT,  32'sd0,         7'd2,   1, ST_DONE,   7'd4},  // middle insert
		'{MODE_DISPLAY, 32'sh12345678,  7'd99,  0, ST_DONE,   7'd0},
		'{MODE_DELETE,  32'sd0,         7'd0,   1, ST_BADPOS, 7'd4},
		'{MODE_DELETE,  32'sd0,         7'd5,   1, ST_BADPOS, 7'd4},  // one past count
		'{MODE_DELETE,  32'sd0,         7'd4,   1, ST_DONE,   7'd3},  // delete tail
		'{MODE_DELETE,  32'sd0,         7'd1,   1, ST_DONE,   7'd2},  // delete head
		'{MODE_UNUSED,  -32'sd1,        7'd127, 1, ST_BADPOS, 7'd2},
		'{MODE_DISPLAY, 32'sd0,         7'd0,   0, ST_DONE,   7'd0},
		'{MODE_INSERT,  32'sh5a5a5a5a,  7'd3,   1, ST_DONE,   7'd3},
		'{MODE_DELETE,  32'sd0,         7'd127, 1, ST_BADPOS, 7'd3}
	};

	always #1 clk = ~clk;

	// status-only result with the count as it stands
	function automatic list_result_t status_result(logic [STATUS_W-1:0] st);
		list_result_t r;
		r.status        = st;
		r.entry_total   = TOTAL_W'(list_count);
		r.element       = '0;
		r.element_valid = 1'b0;
		r.last          = 1'b1;
		return r;
	endfunction

	// list behavior: fills pred_batch with the results of one command
	function automatic void predict_cmd(logic [MODE_W-1:0] mode,
			logic signed [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
		int p;
		list_result_t r;
		p = int'(pos);
		pred_batch.delete();
		case (mode)
			MODE_INSERT: begin
				// position is checked before fullness
				if (p < 1 || p > list_count + 1)
					pred_batch.push_back(status_result(ST_BADPOS));
				else if (list_count >= LIST_DEPTH)
					pred_batch.push_back(status_result(ST_FULL));
				else begin
					for (int i = list_count; i > p - 1; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[p-1] = value;
					list_count++;
					pred_batch.push_back(status_result(ST_DONE));
				end
			end
			MODE_DELETE: begin
				if (p < 1 || p > list_count)
					pred_batch.push_back(status_result(ST_BADPOS));
				else begin
					for (int i = p - 1; i + 1 < list_count; i++)
						list_vals[i] = list_vals[i+1];
					list_count--;
					pred_batch.push_back(status_result(ST_DONE));
				end
			end
			MODE_DISPLAY: begin
				if (list_count == 0)
					pred_batch.push_back(status_result(ST_DONE));
				else begin
					for (int i = 0; i < list_count; i++) begin
						r               = status_result(ST_DONE);
						r.element       = list_vals[i];
						r.element_valid = 1'b1;
						r.last          = (i + 1 == list_count);
						pred_batch.push_back(r);
					end
				end
			end
			default: pred_batch.push_back(status_result(ST_BADPOS));
		endcase
	endfunction

	// drive one command, with a random gap first, and hold it until accepted
	task automatic send_cmd(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({pos, value});
		s_axis_tuser  <= mode;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// send and queue the predicted results
	task automatic issue_cmd(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos);
		send_cmd(mode, value, pos);
		predict_cmd(mode, value, pos);
		foreach (pred_batch[i])
			pending_results.push_back(pred_batch[i]);
	endtask

	// sender holds off until every expected transfer has been seen
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'sh80000000;
			1:       return 32'sh7fffffff;
			2:       return -32'sd1;
			3:       return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// mostly well-formed inserts/deletes, some displays, some noise
	task automatic random_cmd();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 48)
			issue_cmd(MODE_INSERT, pick_value(), POS_W'($urandom_range(1, list_count + 1)));
		else if (sel < 74)
			issue_cmd(MODE_DELETE, pick_value(),
				POS_W'(list_count > 0 ? $urandom_range(1, list_count) : $urandom_range(0, 127)));
		else if (sel < 82)
			issue_cmd(MODE_DISPLAY, pick_value(), POS_W'($urandom_range(0, 127)));
		else if (sel < 92)
			// arbitrary positions; most of them out of range
			issue_cmd(sel[0] ? MODE_INSERT : MODE_DELETE, pick_value(),
				POS_W'($urandom_range(0, 127)));
		else
			issue_cmd(MODE_UNUSED, pick_value(), POS_W'($urandom_range(0, 127)));
	endtask

	// receiver: random backpressure per phase
	always @(posedge clk)
		m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

	// output check: every transfer against the oldest expectation
	always @(posedge clk) begin
		list_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status        = m_axis_tdata[STATUS_W-1:0];
			got.entry_total   = m_axis_tdata[STATUS_W +: TOTAL_W];
			got.element       = m_axis_tdata[STATUS_W+TOTAL_W +: VALUE_W];
			got.element_valid = m_axis_tuser[0];
			got.last          = m_axis_tlast;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transfer: status %0d total %0d element %0d valid %0d last %0d",
						got.status, got.entry_total, got.element, got.element_valid, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.entry_total !== want.entry_total ||
						got.element !== want.element || got.element_valid !== want.element_valid ||
						got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want status %0d total %0d element %0d valid %0d last %0d, got status %0d total %0d element %0d valid %0d last %0d",
							want.status, want.entry_total, want.element, want.element_valid,
							want.last, got.status, got.entry_total, got.element,
							got.element_valid, got.last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		m_axis_tready  = 1'b0;
		list_count     = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 0: directed table, no idling on either side
		foreach (dir_rows[i]) begin
			send_cmd(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].pos);
			predict_cmd(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].pos);
			if (dir_rows[i].typed)
				pending_results.push_back('{dir_rows[i].t_status, dir_rows[i].t_total,
					32'sd0, 1'b0, 1'b1});
			else
				foreach (pred_batch[j])
					pending_results.push_back(pred_batch[j]);
		end

		// fill to capacity at random positions, then hit the full-list cases
		while (list_count < LIST_DEPTH)
			issue_cmd(MODE_INSERT, pick_value(), POS_W'($urandom_range(1, list_count + 1)));
		issue_cmd(MODE_INSERT, pick_value(), 7'd1);                     // full
		issue_cmd(MODE_INSERT, pick_value(), POS_W'(LIST_DEPTH + 1));   // full, tail slot
		issue_cmd(MODE_INSERT, pick_value(), POS_W'(LIST_DEPTH + 2));   // bad position wins
		issue_cmd(MODE_DISPLAY, pick_value(), 7'd0);                    // 64 transfers
		issue_cmd(MODE_DELETE, pick_value(), POS_W'(LIST_DEPTH));
		issue_cmd(MODE_DELETE, pick_value(), POS_W'(LIST_DEPTH));       // now past count

		// four idling phases: none, sender gaps, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			send_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 38 : 0;
			recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 38 : 0;
			repeat (RANDOM_PER_PH)
				random_cmd();
			issue_cmd(MODE_DISPLAY, 32'sd0, 7'd0);
		end

		drain_results();
		// idle wait to catch stray transfers
		repeat (4 * LIST_DEPTH) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_ram.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine_unit.sv
tb/sv/tb.sv
